// File: rtl/oqd_pkg.sv
// Shared types and constants for the ordered ticket queue.
// Holds request, response and internal command formats; no dependencies.
package oqd_pkg;

   localparam int DEPTH          = 32;
   localparam int IDX_W          = $clog2(DEPTH);
   localparam int CNT_W          = $clog2(DEPTH + 1);
   localparam int CMD_FIFO_DEPTH = 2;
   localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
   localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_DUMP   = 2'd2;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_NOKEY = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_INSERT,
      CMD_REMOVE,
      CMD_DUMP
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SHIFT,
      BK_DUMP
   } back_state_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] ticket_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] entry_value;
      logic               entry_valid;
      logic               last_result;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic signed [31:0] value;
   } cmd_type;

endpackage

// File: rtl/ordered_queue_delete_by_key_core.sv
// Top level of the ordered ticket queue with removal by value.
// Depends on oqd_pkg, oqd_front, oqd_cmd_fifo and oqd_back.
//
//   channel   ports                          beat taken when
//   request   req_push, req_full, req_data   req_push && !req_full
//   response  rsp_pop, rsp_empty, rsp_data   rsp_pop && !rsp_empty
//
// Insert completes from the idle state; remove makes a registered compare across all
// entries, then the shift; dump has a setup step, then emits the entries one by one;
// the back-end sequencer handles one command at a time and sets the rate.
// An accepted request passes through the front register and then the command queue to the back end.
// Synchronous reset clears the occupancy, valid flags, pointers and back-end state; entries stay unwritten.
// A stalled response holds the back end; the command queue absorbs new requests meanwhile.
module ordered_queue_delete_by_key_core import oqd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   output rsp_type rsp_data,
   input  logic    rsp_pop
);

   logic    front_valid;
   cmd_type front_cmd;
   logic    fifo_full;
   logic    fifo_empty;
   cmd_type fifo_cmd;
   logic    fifo_pop;

   oqd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_valid (front_valid),
      .cmd_data  (front_cmd),
      .cmd_full  (fifo_full)
   );

   oqd_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_data  (front_cmd),
      .full     (fifo_full),
      .empty    (fifo_empty),
      .rd_data  (fifo_cmd),
      .rd_pop   (fifo_pop)
   );

   oqd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (fifo_empty),
      .cmd_data  (fifo_cmd),
      .cmd_pop   (fifo_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

endmodule

// File: rtl/oqd_front.sv
// Front stage: accepts request beats, classifies the operation, drops unused codes.
// Depends on oqd_pkg.
module oqd_front import oqd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    cmd_valid,
   output cmd_type cmd_data,
   input  logic    cmd_full
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;
   logic    known;
   cmd_type classified;

   always_comb begin
      known            = 1'b1;
      classified.value = req_data.ticket_value;
      classified.kind  = CMD_INSERT;
      case (req_data.operation)
         OP_INSERT: classified.kind = CMD_INSERT;
         OP_REMOVE: classified.kind = CMD_REMOVE;
         OP_DUMP:   classified.kind = CMD_DUMP;
         default:   known = 1'b0;
      endcase
   end

   assign req_full  = valid_ff && cmd_full;
   assign accept    = req_push && !req_full;
   assign cmd_valid = valid_ff;
   assign cmd_data  = cmd_ff;

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (valid_ff && !cmd_full) begin
         valid_in = 1'b0;
      end
      if (accept && known) begin
         valid_in = 1'b1;
         cmd_in   = classified;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

// File: rtl/oqd_cmd_fifo.sv
// Short command queue between the front stage and the back end.
// Depends on oqd_pkg.
module oqd_cmd_fifo import oqd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   input  cmd_type wr_data,
   output logic    full,
   output logic    empty,
   output cmd_type rd_data,
   input  logic    rd_pop
);

   cmd_type                slot_ff [CMD_FIFO_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   logic                   do_wr, do_rd;

   assign full    = count_ff == CMD_CNT_W'(CMD_FIFO_DEPTH);
   assign empty   = count_ff == '0;
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_wr   = wr_valid && !full;
   assign do_rd   = rd_pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                   : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                   : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/oqd_back.sv
// Back end: entry row, compare and shift, dump sequencer and response register.
// Depends on oqd_pkg.
module oqd_back import oqd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   input  cmd_type cmd_data,
   output logic    cmd_pop,
   output logic    rsp_empty,
   output rsp_type rsp_data,
   input  logic    rsp_pop
);

   logic signed [31:0] entries_ff [DEPTH];
   logic signed [31:0] entries_in [DEPTH];
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [DEPTH-1:0]   match_ff, match_in;
   logic [DEPTH-1:0]   first_hit, keep_mask;
   back_state_type     state_ff, state_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;
   logic               out_free;
   logic               is_last;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign first_hit = match_ff & (~match_ff + DEPTH'(1));
   assign keep_mask = first_hit - DEPTH'(1);
   assign is_last   = CNT_W'(idx_ff) == cnt_ff - CNT_W'(1);

   always_comb begin
      match_in = match_ff;
      if (state_ff == BK_IDLE) begin
         for (int i = 0; i < DEPTH; i++) begin
            match_in[i] = (entries_ff[i] == cmd_data.value) && (CNT_W'(i) < cnt_ff);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      cmd_pop      = 1'b0;
      entries_in   = entries_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty && out_free) begin
               cmd_pop = 1'b1;
               out_in  = '{status: ST_OK, entry_value: '0, entry_valid: 1'b0,
                           last_result: 1'b1};
               case (cmd_data.kind)
                  CMD_INSERT: begin
                     out_valid_in = 1'b1;
                     if (cnt_ff == CNT_W'(DEPTH)) begin
                        out_in.status = ST_FULL;
                     end else begin
                        entries_in[cnt_ff[IDX_W-1:0]] = cmd_data.value;
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  CMD_REMOVE: begin
                     if (cnt_ff == '0) begin
                        out_valid_in  = 1'b1;
                        out_in.status = ST_EMPTY;
                     end else begin
                        state_in = BK_SHIFT;
                     end
                  end
                  CMD_DUMP: begin
                     if (cnt_ff == '0) begin
                        out_valid_in  = 1'b1;
                        out_in.status = ST_EMPTY;
                     end else begin
                        idx_in   = '0;
                        state_in = BK_DUMP;
                     end
                  end
                  default: begin
                     out_valid_in = 1'b0;
                  end
               endcase
            end
         end
         BK_SHIFT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in = '{status: ST_OK, entry_value: '0, entry_valid: 1'b0,
                          last_result: 1'b1};
               if (match_ff == '0) begin
                  out_in.status = ST_NOKEY;
               end else begin
                  for (int i = 0; i < DEPTH - 1; i++) begin
                     if (!keep_mask[i]) begin
                        entries_in[i] = entries_ff[i + 1];
                     end
                  end
                  cnt_in = cnt_ff - 1'b1;
               end
               state_in = BK_IDLE;
            end
         end
         BK_DUMP: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in = '{status: ST_OK, entry_value: entries_ff[idx_ff], entry_valid: 1'b1,
                          last_result: is_last};
               idx_in = idx_ff + 1'b1;
               if (is_last) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff     <= idx_in;
      match_ff   <= match_in;
      out_ff     <= out_in;
      entries_ff <= entries_in;
   end

endmodule
